### design/aesd_pkg.sv
`default_nettype none
package aesd_pkg;

  localparam int NumRounds = 10;
  localparam int KeyWords = 4 * (NumRounds + 1);
  localparam int KeyAddrW = $clog2(KeyWords);

  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  typedef struct packed {
    logic [63:0] ct_high;
    logic [63:0] ct_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] pt_high;
    logic [63:0] pt_low;
  } out_item_t;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[a];
  endfunction

endpackage
`default_nettype wire

### design/aesd_ram.sv
`default_nettype none
module aesd_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/aes128_block_decrypt_unit.sv
// AES-128 block decryptor (inverse cipher), one block at a time, ECB style.
// Input channel: in_valid / in_stall with a 128-bit ciphertext in in_data.
// Output channel: out_valid / out_stall with the plaintext in out_data.
// A transfer happens on a rising edge where valid is high and stall is low.
// The key is written through cfg_we / cfg_index / cfg_data (index 0 is the
// high half, 1 the low half). Once the write enable drops after a key write,
// and right after reset, the 44 round-key words are expanded into the key RAM,
// one word a cycle unless a new key write restarts it; the input stalls until it is done.
// A block runs eleven passes: each issues the first read, collects the four
// words of the round key from the key RAM through its one read port, and
// then computes the round itself. The result sits in an output register
// and the block takes no new item until that result is transferred, so a
// new block is taken only once the last result has left. A stall on the
// output holds the result and the input stalls with it.
// Synchronous reset clears control state and marks the key as not expanded;
// the key registers reset to zero.
`default_nettype none
module aes128_block_decrypt_unit
  import aesd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [63:0] cfg_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_EXP, ST_LOAD, ST_RUN, ST_DONE} state_t;

  state_t state;
  logic [63:0] key_high, key_low;
  logic keys_ready;
  logic [127:0] st, blk;
  logic [KeyAddrW-1:0] waddr, raddr;
  logic [KeyAddrW-1:0] ecnt;
  logic [31:0] w0, w1, w2, w3;
  logic [7:0] rcon;
  logic [3:0] rnd;
  logic [1:0] col;
  logic rd_pend;
  logic ram_we;
  logic [31:0] ram_wdata, ram_rdata;
  logic [127:0] key_acc;

  aesd_ram #(.Width(32), .Depth(KeyWords)) u_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(ram_wdata),
    .raddr(raddr), .rdata(ram_rdata)
  );

  function automatic logic [127:0] inv_sr_sb(input logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        r[127-8*(4*c+rw) -: 8] = inv_sbox(s[127-8*(4*((c+4-rw)%4)+rw) -: 8]);
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] x2, x4, x8, acc;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    acc = (b[0] ? a : 8'h00) ^ (b[1] ? x2 : 8'h00) ^ (b[2] ? x4 : 8'h00)
        ^ (b[3] ? x8 : 8'h00);
    return acc;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      r[127-32*c -: 8] = gm(a0,4'd14) ^ gm(a1,4'd11) ^ gm(a2,4'd13) ^ gm(a3,4'd9);
      r[119-32*c -: 8] = gm(a0,4'd9) ^ gm(a1,4'd14) ^ gm(a2,4'd11) ^ gm(a3,4'd13);
      r[111-32*c -: 8] = gm(a0,4'd13) ^ gm(a1,4'd9) ^ gm(a2,4'd14) ^ gm(a3,4'd11);
      r[103-32*c -: 8] = gm(a0,4'd11) ^ gm(a1,4'd13) ^ gm(a2,4'd9) ^ gm(a3,4'd14);
    end
    return r;
  endfunction

  // Key expansion word: w0..w3 hold the last four words.
  logic [31:0] exp_t, exp_word;
  always_comb begin
    exp_t = w3;
    if (ecnt[1:0] == 2'd0) begin
      exp_t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])}
            ^ {rcon, 24'h0};
    end
    exp_word = w0 ^ exp_t;
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = exp_word;
    waddr = ecnt;
    if (state == ST_EXP) begin
      ram_we = 1'b1;
      if (ecnt < KeyAddrW'(4)) begin
        case (ecnt[1:0])
          2'd0: ram_wdata = key_high[63:32];
          2'd1: ram_wdata = key_high[31:0];
          2'd2: ram_wdata = key_low[63:32];
          default: ram_wdata = key_low[31:0];
        endcase
      end
    end
  end

  // Round key word arriving this cycle lands in column col of key_acc.
  logic [127:0] key_full;
  always_comb begin
    key_full = key_acc;
    key_full[127-32*col -: 32] = ram_rdata;
  end

  always_comb begin
    if (rnd == 4'(NumRounds)) begin
      blk = st ^ key_acc;
    end else if (rnd == 4'd0) begin
      blk = inv_sr_sb(st) ^ key_acc;
    end else begin
      blk = inv_mix(inv_sr_sb(st) ^ key_acc);
    end
  end

  assign in_stall = (state != ST_IDLE) || !keys_ready || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      key_high <= '0;
      key_low <= '0;
      keys_ready <= 1'b0;
      out_valid <= 1'b0;
      ecnt <= '0;
      raddr <= '0;
      rd_pend <= 1'b0;
      col <= '0;
      rnd <= '0;
      rcon <= 8'h01;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegKeyHigh: key_high <= cfg_data;
          RegKeyLow:  key_low <= cfg_data;
          default: ;
        endcase
        keys_ready <= 1'b0;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!keys_ready && !cfg_we) begin
            state <= ST_EXP;
            ecnt <= '0;
            rcon <= 8'h01;
          end else if (in_valid && !in_stall) begin
            st <= in_data;
            raddr <= KeyAddrW'(4 * NumRounds);
            col <= '0;
            rnd <= 4'(NumRounds);
            rd_pend <= 1'b1;
            state <= ST_LOAD;
          end
        end
        ST_EXP: begin
          w0 <= w1;
          w1 <= w2;
          w2 <= w3;
          w3 <= ram_wdata;
          if (ecnt >= KeyAddrW'(4) && ecnt[1:0] == 2'd0) begin
            rcon <= xtime(rcon);
          end
          if (cfg_we) begin
            // A key write restarts the expansion once the write enable drops.
            state <= ST_IDLE;
          end else if (ecnt == KeyAddrW'(KeyWords - 1)) begin
            keys_ready <= 1'b1;
            state <= ST_IDLE;
          end else begin
            ecnt <= ecnt + 1'b1;
          end
        end
        ST_LOAD: begin
          // Gathers four key words of the current round, one per cycle.
          if (rd_pend) begin
            rd_pend <= 1'b0;
            raddr <= raddr + 1'b1;
          end else begin
            key_acc <= key_full;
            col <= col + 1'b1;
            if (col == 2'd3) begin
              state <= ST_RUN;
            end else if (col != 2'd2) begin
              raddr <= raddr + 1'b1;
            end
          end
        end
        ST_RUN: begin
          st <= blk;
          if (rnd == 4'd0) begin
            out_data <= blk;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end else begin
            rnd <= rnd - 1'b1;
            raddr <= KeyAddrW'(4 * (rnd - 1'b1));
            rd_pend <= 1'b1;
            col <= '0;
            state <= ST_LOAD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
